/* hdl/fmh_pkg.sv */
package fmh_pkg;

    localparam int THREADS = 16;
    localparam int TID_W   = 4;
    localparam int CNT_W   = $clog2(THREADS + 1);

    typedef logic [TID_W-1:0] tid_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam logic CMD_LOCK   = 1'b0;
    localparam logic CMD_UNLOCK = 1'b1;

    typedef enum logic [2:0] {
        ST_ACQUIRED  = 3'd0,
        ST_OWNER     = 3'd1,
        ST_QUEUED    = 3'd2,
        ST_FREED     = 3'd3,
        ST_HANDOFF   = 3'd4,
        ST_NOT_OWNER = 3'd5,
        ST_FULL      = 3'd6
    } status_t;

    typedef struct packed {
        logic shift;
        logic load;
        tid_t din;
    } cell_ctl_t;

endpackage

/* hdl/fifo_mutex_with_handoff_unit.sv */
// Hardware lock with a first-in first-out wait queue and direct hand-off.
// Each accepted request (lock or unlock, with the requesting thread) gives
// exactly one result from an output register in the cycle after it is
// accepted; a new request is taken in every cycle in which that register is
// empty or being taken, so the sustained rate is one request per cycle. The
// limit is the update of the owner and of the waiter row together: waiters
// sit in a row of cells ordered from the head, a lock request writes the
// first free cell and a hand-off shifts the whole row one cell to the head.
// The queue holds up to THREADS waiters and needs no clearing after reset.
module fifo_mutex_with_handoff_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic                command,
    input  fmh_pkg::tid_t       thread_id,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [2:0]          status,
    output logic                woken_valid,
    output fmh_pkg::tid_t       woken_thread,
    output logic                is_locked,
    output fmh_pkg::tid_t       current_owner
);
    import fmh_pkg::*;

    logic      held_reg;
    logic      held_next;
    tid_t      owner_reg;
    tid_t      owner_next;
    cnt_t      count_reg;
    cnt_t      count_next;

    logic      rsp_valid_reg;
    status_t   status_reg;
    status_t   status_next;
    logic      woken_valid_reg;
    logic      woken_valid_next;
    tid_t      woken_reg;
    tid_t      woken_next;
    logic      locked_reg;
    tid_t      cur_owner_reg;

    logic      accept;
    logic      enq;
    logic      deq;
    logic      hit_owner;

    cell_ctl_t cell_ctl [THREADS];
    tid_t      cell_tid [THREADS];
    tid_t      cell_nxt [THREADS];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign hit_owner = held_reg && (owner_reg == thread_id);

    always_comb
    begin
        held_next        = held_reg;
        owner_next       = owner_reg;
        count_next       = count_reg;
        woken_valid_next = 1'b0;
        woken_next       = '0;
        enq              = 1'b0;
        deq              = 1'b0;
        status_next      = ST_NOT_OWNER;
        if (command == CMD_LOCK)
        begin
            if (hit_owner)
            begin
                status_next = ST_OWNER;
            end
            else if (!held_reg)
            begin
                held_next   = 1'b1;
                owner_next  = thread_id;
                status_next = ST_ACQUIRED;
            end
            else if (count_reg == cnt_t'(THREADS))
            begin
                status_next = ST_FULL;
            end
            else
            begin
                enq         = 1'b1;
                count_next  = count_reg + cnt_t'(1);
                status_next = ST_QUEUED;
            end
        end
        else
        begin
            if (!hit_owner)
            begin
                status_next = ST_NOT_OWNER;
            end
            else if (count_reg != '0)
            begin
                deq              = 1'b1;
                count_next       = count_reg - cnt_t'(1);
                owner_next       = cell_tid[0];
                woken_valid_next = 1'b1;
                woken_next       = cell_tid[0];
                status_next      = ST_HANDOFF;
            end
            else
            begin
                held_next   = 1'b0;
                owner_next  = '0;
                status_next = ST_FREED;
            end
        end
    end

    for (genvar i = 0; i < THREADS; i++)
    begin : g_cell
        assign cell_ctl[i].shift = accept && deq;
        assign cell_ctl[i].load  = accept && enq && (count_reg == cnt_t'(i));
        assign cell_ctl[i].din   = thread_id;
        if (i == THREADS - 1)
        begin : g_last
            assign cell_nxt[i] = '0;
        end
        else
        begin : g_mid
            assign cell_nxt[i] = cell_tid[i+1];
        end
        fmh_cell u_cell (
            .clk      (clk),
            .ctl      (cell_ctl[i]),
            .next_tid (cell_nxt[i]),
            .tid      (cell_tid[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= 1'b0;
            owner_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                held_reg  <= held_next;
                owner_reg <= owner_next;
                count_reg <= count_next;
            end
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            woken_valid_reg <= woken_valid_next;
            woken_reg       <= woken_next;
            locked_reg      <= held_next;
            cur_owner_reg   <= held_next ? owner_next : '0;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign woken_valid   = woken_valid_reg;
    assign woken_thread  = woken_reg;
    assign is_locked     = locked_reg;
    assign current_owner = cur_owner_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(THREADS))
        else $error("waiter count above capacity");

    a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !held_reg |-> (count_reg == '0 && owner_reg == '0))
        else $error("free lock with waiters or stale owner");

    a_handoff_woken: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (woken_valid_reg == (status_reg == ST_HANDOFF)))
        else $error("woken flag disagrees with status");

    a_handoff_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && deq |=> count_reg == $past(count_reg) - cnt_t'(1))
        else $error("hand-off did not pop the queue");

endmodule

/* hdl/fmh_cell.sv */
module fmh_cell (
    input  logic              clk,
    input  fmh_pkg::cell_ctl_t ctl,
    input  fmh_pkg::tid_t     next_tid,
    output fmh_pkg::tid_t     tid
);
    import fmh_pkg::*;

    tid_t tid_reg;
    tid_t tid_next;

    always_comb
    begin
        tid_next = tid_reg;
        if (ctl.load)
        begin
            tid_next = ctl.din;
        end
        else if (ctl.shift)
        begin
            tid_next = next_tid;
        end
    end

    always_ff @(posedge clk)
    begin
        tid_reg <= tid_next;
    end

    assign tid = tid_reg;

endmodule
